FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands on clk_i with reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property each clock outside reset.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
  `ASSERT_PROP(label, (ante) |-> (cons), msg)

// Check that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  `ASSERT_PROP(label, (ante) |=> (cons), msg)

`endif

FILE: rtl/cpu8ie_pkg.sv
// ----------------------------------------------------------------------------
// cpu8ie_pkg
// Opcodes, status codes and item layouts of the 8-bit instruction executor.
// ----------------------------------------------------------------------------
package cpu8ie_pkg;

  localparam int unsigned REG_NUM = 16;
  localparam int unsigned REG_AW  = 4;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned PC_W    = 16;
  localparam int unsigned KIND_W  = 4;
  localparam int unsigned IN_W    = 24;
  localparam int unsigned OUT_W   = 40;

  typedef enum logic [KIND_W-1:0] {
    OP_ADDI    = 4'd0,
    OP_ADDC    = 4'd1,
    OP_SUB     = 4'd2,
    OP_AND     = 4'd3,
    OP_OR      = 4'd4,
    OP_XOR     = 4'd5,
    OP_ANDI    = 4'd6,
    OP_LOADI   = 4'd7,
    OP_XORI    = 4'd8,
    OP_RSHIFT  = 4'd9,
    OP_ROTATE  = 4'd10,
    OP_BRANCH  = 4'd11,
    OP_JUMPREG = 4'd12,
    OP_WRITE   = 4'd13,
    OP_READ    = 4'd14,
    OP_ADD     = 4'd15
  } opcode_e;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // Input item as {tdata, tuser}, lowest bits first: kind, dest_field, src_a,
  // src_b, imm_low, input_byte.
  typedef struct packed {
    logic [BYTE_W-1:0] input_byte;
    logic [3:0]        imm_low;
    logic [REG_AW-1:0] src_b;
    logic [REG_AW-1:0] src_a;
    logic [REG_AW-1:0] dest_field;
    opcode_e           kind;
  } in_item_t;

  // Result item, lowest bits first: status, next_pc, write_valid, write_first,
  // write_second.
  typedef struct packed {
    logic [5:0]        pad;
    logic [BYTE_W-1:0] write_second;
    logic [BYTE_W-1:0] write_first;
    logic              write_valid;
    logic [PC_W-1:0]   next_pc;
    logic              status;
  } out_item_t;

endpackage

FILE: rtl/cpu8_instruction_execute.sv
// ----------------------------------------------------------------------------
// cpu8_instruction_execute
// Executes one instruction of a small 8-bit CPU per item.
//
//   channel   direction   handshake                       payload
//   s_axis    in          s_axis_tvalid / s_axis_tready   instruction item, kind on tuser
//   m_axis    out         m_axis_tvalid / m_axis_tready   status, pc, byte pair
//   cfg       in          cfg_valid_i / cfg_ready_o       program_length
//
// One item per cycle while m_axis is not stalled; the item is registered in the
// execute stage, then its result in the output register that drives m_axis.
// Register file reads are registered from the synchronous memories; the execute
// stage forwards the write done at the edge where its reads were captured.
// Reset clears entry valid bits at once, so no clearing pass is needed.
// A stalled result holds a full execute stage and with it the input; every
// edge at which the result leaves frees one slot.
// ----------------------------------------------------------------------------
module cpu8_instruction_execute
  import cpu8ie_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // kind[3:0]
  input  logic [KIND_W-1:0] s_axis_tuser,
  // dest_field[3:0], src_a[7:4], src_b[11:8], imm_low[15:12], input_byte[23:16]
  input  logic [IN_W-1:0]   s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // status[0], next_pc[16:1], write_valid[17], write_first[25:18],
  // write_second[33:26], zero[39:34]
  output logic [OUT_W-1:0]  m_axis_tdata,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [PC_W-1:0]   cfg_data_i
);

  in_item_t          in_item;
  in_item_t          ex_q;
  logic              ex_valid_q;
  logic              s_fire;
  logic              ex_fire;

  logic [BYTE_W-1:0] mem_ab [REG_NUM];
  logic [BYTE_W-1:0] mem_d  [REG_NUM];
  logic [REG_NUM-1:0] ent_vld_q;
  logic [BYTE_W-1:0] rd_a_q, rd_b_q, rd_d_q;
  logic              vl_a_q, vl_b_q, vl_d_q;

  logic              wr_en;
  logic [REG_AW-1:0] wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic              fwd_en_q;
  logic [REG_AW-1:0] fwd_addr_q;
  logic [BYTE_W-1:0] fwd_data_q;

  logic [PC_W-1:0]   prog_len_q;
  logic              carry_q, overflow_q;
  opcode_e           prev_op_q;
  logic [BYTE_W-1:0] prev_res_q;
  logic [PC_W-1:0]   pc_q;

  logic              out_valid_q;
  out_item_t         out_q;
  out_item_t         out_d;

  logic [BYTE_W-1:0] ra, rb, rd_old, res, imm;
  logic [BYTE_W-1:0] add_y;
  logic              add_cin;
  logic [BYTE_W:0]   sum9;
  logic [BYTE_W-1:0] low8;
  logic              carry_in, carry_new, overflow_new, writes_reg, keep_carry;
  logic              take, in_range;
  logic [PC_W-1:0]   npc;

  assign in_item       = in_item_t'({s_axis_tdata, s_axis_tuser});
  assign cfg_ready_o   = 1'b1;
  assign ex_fire       = ex_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !ex_valid_q || ex_fire;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'(out_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_ab[wr_addr] <= wr_data;
      mem_d[wr_addr]  <= wr_data;
    end
    if (s_fire) begin
      rd_a_q <= mem_ab[in_item.src_a];
      rd_b_q <= mem_ab[in_item.src_b];
      rd_d_q <= mem_d[in_item.dest_field];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q  <= '0;
      vl_a_q     <= 1'b0;
      vl_b_q     <= 1'b0;
      vl_d_q     <= 1'b0;
      fwd_en_q   <= 1'b0;
      ex_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        ent_vld_q[wr_addr] <= 1'b1;
      end
      if (s_fire) begin
        vl_a_q   <= ent_vld_q[in_item.src_a];
        vl_b_q   <= ent_vld_q[in_item.src_b];
        vl_d_q   <= ent_vld_q[in_item.dest_field];
        fwd_en_q <= wr_en;
      end
      if (s_fire) begin
        ex_valid_q <= 1'b1;
      end else if (ex_fire) begin
        ex_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      ex_q       <= in_item;
      fwd_addr_q <= wr_addr;
      fwd_data_q <= wr_data;
    end
  end

  always_comb begin
    ra     = vl_a_q ? rd_a_q : '0;
    rb     = vl_b_q ? rd_b_q : '0;
    rd_old = vl_d_q ? rd_d_q : '0;
    if (fwd_en_q && fwd_addr_q == ex_q.src_a)      ra     = fwd_data_q;
    if (fwd_en_q && fwd_addr_q == ex_q.src_b)      rb     = fwd_data_q;
    if (fwd_en_q && fwd_addr_q == ex_q.dest_field) rd_old = fwd_data_q;
  end

  always_comb begin
    imm      = {ex_q.src_b, ex_q.imm_low};
    carry_in = (prev_op_q == OP_SUB && ex_q.kind != OP_SUB) ? 1'b0 : carry_q;
    in_range = pc_q < prog_len_q;

    add_y   = rb;
    add_cin = 1'b0;
    case (ex_q.kind)
      OP_ADDI: add_y = imm;
      OP_ADDC: add_cin = carry_in;
      OP_SUB: begin
        add_y   = ~rb;
        add_cin = (prev_op_q == OP_SUB) ? carry_q : 1'b1;
      end
      default: add_y = rb;
    endcase
    sum9 = {1'b0, ra} + {1'b0, add_y} + {{BYTE_W{1'b0}}, add_cin};
    low8 = {1'b0, ra[BYTE_W-2:0]} + {1'b0, add_y[BYTE_W-2:0]}
         + {{(BYTE_W-1){1'b0}}, add_cin};

    res          = sum9[BYTE_W-1:0];
    carry_new    = sum9[BYTE_W];
    overflow_new = overflow_q;
    writes_reg   = 1'b1;
    take         = 1'b0;
    npc          = pc_q + PC_W'(1);

    unique case (ex_q.kind) inside
      OP_ADDI, OP_ADDC, OP_ADD: begin
        overflow_new = low8[BYTE_W-1] ^ sum9[BYTE_W];
      end
      OP_SUB: begin
        carry_new    = ~sum9[BYTE_W];
        overflow_new = low8[BYTE_W-1] ^ ~sum9[BYTE_W];
      end
      OP_AND:   res = ra & rb;
      OP_OR:    res = ra | rb;
      OP_XOR:   res = ra ^ rb;
      OP_ANDI:  res = ra & imm;
      OP_LOADI: res = imm;
      OP_XORI:  res = ra ^ imm;
      OP_RSHIFT: begin
        res       = {carry_in, ra[BYTE_W-1:1]};
        carry_new = ra[0];
      end
      OP_ROTATE: begin
        res       = {ra[0], ra[BYTE_W-1:1]};
        carry_new = ra[0];
      end
      OP_BRANCH: begin
        writes_reg = 1'b0;
        take = (ex_q.dest_field == '0)
            || (ex_q.dest_field[3] && prev_res_q == '0)
            || (ex_q.dest_field[2] && prev_res_q[BYTE_W-1])
            || (ex_q.dest_field[1] && carry_in)
            || (ex_q.dest_field[0] && overflow_q);
        if (take) npc = PC_W'({ex_q.src_a, imm});
      end
      OP_JUMPREG: begin
        writes_reg = 1'b0;
        npc        = {ra, rb};
      end
      OP_WRITE: writes_reg = 1'b0;
      OP_READ:  res = ex_q.input_byte;
      default:  res = sum9[BYTE_W-1:0];
    endcase

    case (ex_q.kind) inside
      OP_ADDI, OP_ADDC, OP_SUB, OP_RSHIFT, OP_ROTATE, OP_ADD: keep_carry = 1'b1;
      default: keep_carry = 1'b0;
    endcase

    wr_en   = ex_fire && in_range && writes_reg;
    wr_addr = ex_q.dest_field;
    wr_data = res;

    out_d              = '0;
    out_d.status       = in_range ? STATUS_OK : STATUS_RANGE;
    out_d.next_pc      = in_range ? npc : pc_q;
    out_d.write_valid  = in_range && ex_q.kind == OP_WRITE;
    out_d.write_first  = out_d.write_valid ? ra : '0;
    out_d.write_second = out_d.write_valid ? rb : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_len_q  <= '1;
      carry_q     <= 1'b0;
      overflow_q  <= 1'b0;
      prev_op_q   <= OP_ADDI;
      prev_res_q  <= '0;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        prog_len_q <= cfg_data_i;
      end
      if (ex_fire && in_range) begin
        carry_q    <= keep_carry ? carry_new : 1'b0;
        overflow_q <= overflow_new;
        prev_op_q  <= ex_q.kind;
        prev_res_q <= writes_reg ? res : rd_old;
        pc_q       <= npc;
      end
      if (ex_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_fire) begin
      out_q <= out_d;
    end
  end

endmodule

FILE: rtl/cpu8ie_checker.sv
// ----------------------------------------------------------------------------
// cpu8ie_checker
// Port-level checks of the 8-bit instruction executor, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpu8ie_checker
  import cpu8ie_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [OUT_W-1:0]  m_axis_tdata
);

  out_item_t res;

  assign res = out_item_t'(m_axis_tdata);

  `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
  `ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "unstable")
  `ASSERT_IMPL(a_range_no_write, m_axis_tvalid && res.status == STATUS_RANGE, !res.write_valid,
               "write on range error")
  `ASSERT_IMPL(a_pair_zero, m_axis_tvalid && !res.write_valid,
               res.write_first == '0 && res.write_second == '0, "byte pair without write")
  `ASSERT_IMPL(a_in_ready, !m_axis_tvalid, s_axis_tready, "input blocked with output empty")

endmodule

bind cpu8_instruction_execute cpu8ie_checker u_cpu8ie_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
